FILE: rtl/dtq_pkg.sv
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_FIRES = 16;
  localparam int ID_W = 32;
  localparam int WAIT_W = 49;

  // Input operation codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Result kinds.
  localparam logic [2:0] K_ADDED = 3'd0;
  localparam logic [2:0] K_FIRED = 3'd1;
  localparam logic [2:0] K_CANCELLED = 3'd2;
  localparam logic [2:0] K_NOT_FOUND = 3'd3;
  localparam logic [2:0] K_FULL = 3'd4;
  localparam logic [2:0] K_WAIT = 3'd5;

endpackage

FILE: rtl/deadline_timer_queue_top.sv
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// command   start / busy        opcode, delay, delay_in_seconds, cancel_id
// result    strobe (one cycle)  kind, timer_id, wait_ms, last
//
// Add, cancel and query take one scan of the entry memory: busy falls in the
// cycle in which the result is shown, and the next item can be accepted at the
// edge that takes the result. A tick runs one scan per fired timer plus one more
// (none more once the fire budget is spent), and each fired result is shown one
// scan late so that last lands on the final one; when sixteen fire, the final
// result follows the fifteenth in the next cycle.
// Reset clears the valid bits, the time counter and the id counter at once.
// Results are shown for one cycle and cannot be stalled.
module deadline_timer_queue_top #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic [31:0]                  delay,
  input  logic                         delay_in_seconds,
  input  logic [31:0]                  cancel_id,
  output logic                         strobe,
  output logic [2:0]                   kind,
  output logic [31:0]                  timer_id,
  output logic signed [dtq_pkg::WAIT_W-1:0] wait_ms,
  output logic                         last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 2);
  localparam int FW = $clog2(dtq_pkg::MAX_FIRES + 1);
  localparam int SPAN_W = 42;
  localparam int SUMW = ((TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
  localparam logic [CW-1:0] LASTIDX = CW'(DEPTH - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DONE, S_FIRE} state_t;

  // Entry memory: deadline and id, registered read.
  logic [TIME_BITS+31:0] mem [DEPTH];
  logic [TIME_BITS+31:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TIME_BITS+31:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [DEPTH-1:0] valid;
  logic [TIME_BITS-1:0] now_ms;
  logic [31:0] id_counter;
  state_t state;
  logic [1:0] op;
  logic [SPAN_W-1:0] span;
  logic [31:0] cid;
  logic [CW-1:0] cnt;
  logic [AW-1:0] rslot;
  logic rvalid;
  logic found;
  logic [AW-1:0] best;
  logic [TIME_BITS-1:0] best_dl;
  logic [31:0] best_id;
  logic [FW-1:0] nfired;
  logic have_prev;
  logic [31:0] prev_id;
  logic [AW-1:0] free_slot;
  logic free_any;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    free_any = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = AW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [TIME_BITS-1:0] r_dl;
  logic [31:0] r_id;
  logic better;
  logic due;
  logic [SUMW-1:0] dl_sum;
  logic dl_sat;
  logic [TIME_BITS-1:0] diff;

  assign r_dl = rd_data[TIME_BITS+31:32];
  assign r_id = rd_data[31:0];
  assign better = !found || (r_dl < best_dl) || (r_dl == best_dl && r_id < best_id);
  assign due = found && (best_dl <= now_ms);
  assign dl_sum = SUMW'(now_ms) + SUMW'(span);
  assign dl_sat = (dl_sum[SUMW-1:TIME_BITS] != '0);
  assign diff = best_dl - now_ms;
  assign rd_addr = cnt[AW-1:0];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = free_slot;
    wr_data = {(dl_sat ? TMAX : dl_sum[TIME_BITS-1:0]), id_counter + 32'd1};
    if (state == S_DONE && op == dtq_pkg::OP_ADD && free_any) begin
      wr_en = 1'b1;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequencer: scans memory, then emits results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      now_ms <= '0;
      id_counter <= '0;
      strobe <= 1'b0;
      cnt <= '0;
      rvalid <= 1'b0;
      found <= 1'b0;
      nfired <= '0;
      have_prev <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            op <= opcode;
            cid <= cancel_id;
            span <= delay_in_seconds ? {10'd0, delay} * 42'd1000 : {10'd0, delay};
            if (opcode == dtq_pkg::OP_TICK && now_ms != TMAX) begin
              now_ms <= now_ms + 1'b1;
            end
            nfired <= '0;
            have_prev <= 1'b0;
            cnt <= '0;
            rvalid <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          strobe <= 1'b0;
          rvalid <= (cnt <= LASTIDX);
          rslot <= cnt[AW-1:0];
          if (rvalid && valid[rslot]) begin
            if (op == dtq_pkg::OP_CANCEL) begin
              if (!found && r_id == cid) begin
                found <= 1'b1;
                best <= rslot;
              end
            end else if (better) begin
              found <= 1'b1;
              best <= rslot;
              best_dl <= r_dl;
              best_id <= r_id;
            end
          end
          if (cnt == CW'(DEPTH)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          wait_ms <= '0;
          case (op)
            dtq_pkg::OP_ADD: begin
              strobe <= 1'b1;
              last <= 1'b1;
              state <= S_IDLE;
              if (free_any) begin
                kind <= dtq_pkg::K_ADDED;
                timer_id <= id_counter + 32'd1;
                id_counter <= id_counter + 32'd1;
                valid[free_slot] <= 1'b1;
              end else begin
                kind <= dtq_pkg::K_FULL;
                timer_id <= '0;
              end
            end
            dtq_pkg::OP_CANCEL: begin
              strobe <= 1'b1;
              last <= 1'b1;
              state <= S_IDLE;
              timer_id <= cid;
              if (found) begin
                kind <= dtq_pkg::K_CANCELLED;
                valid[best] <= 1'b0;
              end else begin
                kind <= dtq_pkg::K_NOT_FOUND;
              end
            end
            dtq_pkg::OP_TICK: begin
              // Show the timer fired by the previous scan; it is final unless
              // this scan found another one due.
              strobe <= have_prev;
              kind <= dtq_pkg::K_FIRED;
              timer_id <= prev_id;
              last <= !due;
              if (due) begin
                valid[best] <= 1'b0;
                nfired <= nfired + 1'b1;
                prev_id <= best_id;
                have_prev <= 1'b1;
                state <= S_FIRE;
              end else begin
                state <= S_IDLE;
              end
            end
            default: begin
              strobe <= 1'b1;
              last <= 1'b1;
              state <= S_IDLE;
              kind <= dtq_pkg::K_WAIT;
              timer_id <= '0;
              if (!found) begin
                wait_ms <= '1;
              end else if (best_dl <= now_ms) begin
                wait_ms <= '0;
              end else if (TIME_BITS > 48 && (diff >> 48) != '0) begin
                wait_ms <= {1'b0, {48{1'b1}}};
              end else begin
                wait_ms <= dtq_pkg::WAIT_W'(diff);
              end
            end
          endcase
        end
        S_FIRE: begin
          // With the fire budget spent, the held timer is the final result;
          // otherwise scan again for the next due timer.
          if (nfired == FW'(dtq_pkg::MAX_FIRES)) begin
            strobe <= 1'b1;
            kind <= dtq_pkg::K_FIRED;
            timer_id <= prev_id;
            wait_ms <= '0;
            last <= 1'b1;
            state <= S_IDLE;
          end else begin
            strobe <= 1'b0;
            cnt <= '0;
            rvalid <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        default: begin
          strobe <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dtq_checker.sv
`timescale 1ns / 1ps
module dtq_port_props (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [2:0] kind,
  input logic       last
);

  // An accepted item makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // Non-tick results are always the final one.
  a_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind != dtq_pkg::K_FIRED |-> last) else $error("single result lacks last");

  // Kind codes stay in range.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    strobe |-> kind <= dtq_pkg::K_WAIT) else $error("bad kind");

  // Idle after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !busy && !strobe)
    else $error("not idle after reset");

endmodule

bind deadline_timer_queue_top dtq_port_props u_dtq_port_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .strobe(strobe), .kind(kind), .last(last)
);
